/* hw/rtl/css_pkg.sv */
// Shared types and codes for the cocktail shaker sorter.
// Used by css_ctrl, css_dpath and cocktail_shaker_sorter_core; no dependencies.
package css_pkg;

   localparam int VALUE_W = 32;

   // Write data source select for the element store
   localparam logic [1:0] SRC_INPUT = 2'd0;
   localparam logic [1:0] SRC_SWAP  = 2'd1;
   localparam logic [1:0] SRC_CARRY = 2'd2;

   // Input item
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      is_last;
   } req_type;

   // Result item
   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      end_of_set;
      logic                      overflowed;
   } rsp_type;

   // Per-cycle command from the controller to the datapath
   typedef struct packed {
      logic       wr_en;
      logic [1:0] wr_src;
      logic       load_carry;
      logic       step;
      logic       fwd;
      logic       emit;
      logic       emit_last;
      logic       emit_ovf;
   } cmd_type;

endpackage

/* hw/rtl/css_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module css_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/css_dpath.sv */
// Datapath: element store, carry register, compare-swap and result register.
// Depends on css_pkg and css_ram.
module css_dpath
   import css_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   input  logic signed [VALUE_W-1:0]   in_value,
   input  logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  logic [$clog2(CAPACITY)-1:0] rd_addr,
   output logic                        rsp_valid,
   output rsp_type                     rsp_item
);

   logic [VALUE_W-1:0]        wr_data;
   logic [VALUE_W-1:0]        rd_raw;
   logic signed [VALUE_W-1:0] rdata;
   logic signed [VALUE_W-1:0] carry_ff;
   logic signed [VALUE_W-1:0] carry_in;
   logic signed [VALUE_W-1:0] swap_data;
   logic                      keep;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   css_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rdata = $signed(rd_raw);

   // Compare: carry is the left neighbor going forward, the right one going back
   always_comb begin
      keep      = cmd.fwd ? (carry_ff > rdata) : (rdata > carry_ff);
      swap_data = keep ? rdata : carry_ff;
   end

   // Store write data select
   always_comb begin
      unique case (cmd.wr_src)
         SRC_INPUT: wr_data = in_value;
         SRC_SWAP:  wr_data = swap_data;
         SRC_CARRY: wr_data = carry_ff;
         default:   wr_data = carry_ff;
      endcase
   end

   // Carry holds the element being bubbled through the pass
   always_comb begin
      carry_in = carry_ff;
      if (cmd.load_carry) begin
         carry_in = rdata;
      end else if (cmd.step) begin
         carry_in = keep ? carry_ff : rdata;
      end
   end

   // Result register, one cycle strobe per transfer
   always_comb begin
      rsp_in.sorted_value = rdata;
      rsp_in.end_of_set   = cmd.emit_last;
      rsp_in.overflowed   = cmd.emit_ovf;
      rsp_valid_in        = cmd.emit;
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* hw/rtl/css_ctrl.sv */
// Controller: fill counter, pass bounds, pass sequencing and output sequencing.
// Depends on css_pkg.
module css_ctrl
   import css_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        is_last,
   output logic                        busy,
   output cmd_type                     cmd,
   output logic [$clog2(CAPACITY)-1:0] wr_addr,
   output logic [$clog2(CAPACITY)-1:0] rd_addr
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_PASS     = 3'd1;
   localparam logic [2:0] S_LOAD     = 3'd2;
   localparam logic [2:0] S_PRIME    = 3'd3;
   localparam logic [2:0] S_RUN      = 3'd4;
   localparam logic [2:0] S_LAST     = 3'd5;
   localparam logic [2:0] S_OUT_LOAD = 3'd6;
   localparam logic [2:0] S_OUT      = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] lo_ff, lo_in;
   logic [AW-1:0] hi_ff, hi_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          fwd_ff, fwd_in;

   logic          full;
   logic [CW-1:0] n_last;
   logic [AW-1:0] nxt;
   logic [AW-1:0] nxt2;
   logic [AW-1:0] end_addr;
   logic [AW-1:0] start_addr;

   // Address helpers for the current pass direction
   always_comb begin
      full       = (count_ff == CW'(CAPACITY));
      n_last     = full ? count_ff : count_ff + CW'(1);
      nxt        = fwd_ff ? idx_ff + AW'(1) : idx_ff - AW'(1);
      nxt2       = fwd_ff ? nxt + AW'(1) : nxt - AW'(1);
      end_addr   = fwd_ff ? hi_ff : lo_ff;
      start_addr = fwd_ff ? lo_ff : hi_ff - AW'(1);
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      fwd_in   = fwd_ff;
      cmd      = '0;
      cmd.fwd  = fwd_ff;
      wr_addr  = idx_ff;
      rd_addr  = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (!full) begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_src = SRC_INPUT;
                  wr_addr    = count_ff[AW-1:0];
                  count_in   = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (is_last) begin
                  lo_in    = '0;
                  hi_in    = AW'(n_last - CW'(1));
                  state_in = S_PASS;
               end
            end
         end
         S_PASS: begin
            if (lo_ff < hi_ff) begin
               fwd_in   = 1'b1;
               state_in = S_LOAD;
            end else begin
               state_in = S_OUT_LOAD;
            end
         end
         S_LOAD: begin
            rd_addr  = start_addr;
            idx_in   = start_addr;
            state_in = S_PRIME;
         end
         S_PRIME: begin
            cmd.load_carry = 1'b1;
            rd_addr        = nxt;
            state_in       = S_RUN;
         end
         S_RUN: begin
            // one compare-swap per cycle, writing back the settled neighbor
            cmd.step   = 1'b1;
            cmd.wr_en  = 1'b1;
            cmd.wr_src = SRC_SWAP;
            rd_addr    = nxt2;
            idx_in     = nxt;
            if (nxt == end_addr) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = SRC_CARRY;
            if (fwd_ff && (hi_ff > lo_ff + AW'(1))) begin
               fwd_in   = 1'b0;
               state_in = S_LOAD;
            end else begin
               lo_in    = lo_ff + AW'(1);
               hi_in    = hi_ff - AW'(1);
               state_in = S_PASS;
            end
         end
         S_OUT_LOAD: begin
            rd_addr  = '0;
            idx_in   = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.emit     = 1'b1;
            cmd.emit_ovf = ovf_ff;
            rd_addr      = idx_ff + AW'(1);
            idx_in       = idx_ff + AW'(1);
            if (CW'(idx_ff) + CW'(1) == count_ff) begin
               cmd.emit_last = 1'b1;
               count_in      = '0;
               ovf_in        = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Pass bounds and walk index
   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      idx_ff <= idx_in;
      fwd_ff <= fwd_in;
   end

   assign busy = (state_ff != S_IDLE);

`ifndef NO_ASSERTIONS
   a_last_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && is_last) |=> busy)
      else $error("last item accepted but controller stayed idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("fill count beyond capacity");

   a_final_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_last |=> (!busy && count_ff == '0 && !ovf_ff))
      else $error("set not cleared after final result");

   a_run_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN || state_ff == S_PRIME) |-> (lo_ff < hi_ff))
      else $error("pass running over an empty range");
`endif

endmodule

/* hw/rtl/cocktail_shaker_sorter_core.sv */
// Cocktail shaker sorter: values are collected one per transfer while idle, and
// the transfer marked is_last starts an in-place sort of the set, after which the
// n sorted results stream out on consecutive cycles, one per rsp_valid strobe,
// with end_of_set on the largest. The receiver cannot stall, so it must take a
// result on every cycle rsp_valid is high. busy is low only while collecting.
// A set of n values is accepted one per transfer, then sorted by the single
// compare-swap unit, which walks the store through its one read port at one
// neighbor pair per cycle, then streamed out. Values beyond CAPACITY are
// dropped and every result of that set has overflowed set.
// Depends on css_pkg, css_ctrl, css_dpath and css_ram.
module cocktail_shaker_sorter_core
   import css_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int AW = $clog2(CAPACITY);

   cmd_type       cmd;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   css_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .is_last (req_item.is_last),
      .busy    (busy),
      .cmd     (cmd),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr)
   );

   css_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .in_value  (req_item.value),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for cocktail_shaker_sorter_core: queues value sets,
// predicts the sorted result stream of each set and compares it transfer by transfer.
// Depends on css_pkg and the sorter RTL.
`timescale 1ns / 100ps

module testbench;
   import css_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int CYCLE_LIMIT = 500000;
   localparam int TAIL_CYCLES = 150;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   // One queued input transfer plus how the driver should present it
   typedef struct {
      req_type item;
      bit      drain_first;  // hold off until every pending result is out
      bit      no_gap;       // never idle before this one
   } pending_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   pending_type pending_q[$];
   rsp_type     sorted_expect_q[$];
   logic signed [VALUE_W-1:0] collected_q[$];
   bit          spill_seen;
   logic        item_taken;
   int          error_count;
   int          cycle_count;

   cocktail_shaker_sorter_core #(.CAPACITY(CAPACITY)) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Clock
   always #5 clock = ~clock;

   // Predictor: collect the set, sort it on the last transfer, queue the results
   task automatic absorb_item(input req_type it);
      logic signed [VALUE_W-1:0] work[CAPACITY];
      logic signed [VALUE_W-1:0] tmp;
      rsp_type r;
      int n;
      int p;
      int i;
      if (collected_q.size() < CAPACITY) collected_q.push_back(it.value);
      else spill_seen = 1'b1;
      if (it.is_last) begin
         n = collected_q.size();
         for (i = 0; i < n; i++) work[i] = collected_q[i];
         for (p = 1; p <= n / 2; p++) begin
            for (i = p - 1; i + p < n; i++) begin
               if (work[i] > work[i+1]) begin
                  tmp = work[i]; work[i] = work[i+1]; work[i+1] = tmp;
               end
            end
            for (i = n - p - 1; i >= p; i--) begin
               if (work[i-1] > work[i]) begin
                  tmp = work[i]; work[i] = work[i-1]; work[i-1] = tmp;
               end
            end
         end
         for (i = 0; i < n; i++) begin
            r.sorted_value = work[i];
            r.end_of_set   = (i == n - 1);
            r.overflowed   = spill_seen;
            sorted_expect_q.push_back(r);
         end
         collected_q.delete();
         spill_seen = 1'b0;
      end
   endtask

   task automatic queue_value(input logic signed [VALUE_W-1:0] v, input bit last,
                              input bit drain, input bit burst);
      pending_type s;
      s.item.value   = v;
      s.item.is_last = last;
      s.drain_first  = drain;
      s.no_gap       = burst;
      pending_q.push_back(s);
   endtask

   // Mix of full-range, extreme, clustered and near-edge values
   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(5))
         0: v = $urandom;
         1: case ($urandom_range(3))
               0: v = VAL_MIN;
               1: v = VAL_MAX;
               2: v = '0;
               default: v = '1;
            endcase
         2: v = $signed($urandom_range(8)) - 4;
         3: v = VAL_MAX - $signed($urandom_range(3));
         4: v = VAL_MIN + $signed($urandom_range(3));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic queue_set(input int n, input bit drain, input bit burst);
      int k;
      for (k = 0; k < n; k++)
         queue_value(pick_value(), k == n - 1, drain && k == 0, burst);
   endtask

   // Driver: present queued transfers on the falling edge
   always @(negedge clock) begin : drive_req
      pending_type next_slot;
      if (!reset) begin
         if (!start || item_taken) begin
            if (pending_q.size() == 0) begin
               start <= 1'b0;
            end else if (pending_q[0].drain_first &&
                         (sorted_expect_q.size() != 0 || busy)) begin
               start <= 1'b0;
            end else if (!pending_q[0].no_gap && $urandom_range(99) < 19) begin
               start <= 1'b0;
            end else begin
               next_slot = pending_q.pop_front();
               req_item <= next_slot.item;
               start    <= 1'b1;
            end
         end
      end
   end

   // Monitor: check results, feed accepted transfers to the predictor
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (reset) begin
         item_taken <= 1'b0;
      end else begin
         item_taken <= start && !busy;
         if (rsp_valid) begin
            if (sorted_expect_q.size() == 0) begin
               $error("unexpected result: sorted_value %0d", rsp_item.sorted_value);
               error_count++;
            end else begin
               want = sorted_expect_q.pop_front();
               if (rsp_item.sorted_value !== want.sorted_value) begin
                  $error("sorted_value: expected %0d, actual %0d",
                         want.sorted_value, rsp_item.sorted_value);
                  error_count++;
               end
               if (rsp_item.end_of_set !== want.end_of_set) begin
                  $error("end_of_set: expected %0b, actual %0b",
                         want.end_of_set, rsp_item.end_of_set);
                  error_count++;
               end
               if (rsp_item.overflowed !== want.overflowed) begin
                  $error("overflowed: expected %0b, actual %0b",
                         want.overflowed, rsp_item.overflowed);
                  error_count++;
               end
            end
         end
         if (start && !busy) absorb_item(req_item);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin : run
      int set_idx;
      int rand_items;
      int n;
      bit burst;
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      item_taken  = 1'b0;
      spill_seen  = 1'b0;
      error_count = 0;
      cycle_count = 0;

      // Directed: single element, extremes, duplicates, sorted and reversed input
      queue_value(VAL_MIN, 1'b1, 1'b0, 1'b0);
      queue_value(VAL_MAX, 1'b0, 1'b0, 1'b0);
      queue_value(VAL_MIN, 1'b1, 1'b0, 1'b0);
      queue_value(0,       1'b0, 1'b0, 1'b0);
      queue_value(-1,      1'b0, 1'b0, 1'b0);
      queue_value(VAL_MAX, 1'b0, 1'b0, 1'b0);
      queue_value(VAL_MIN, 1'b0, 1'b0, 1'b0);
      queue_value(1,       1'b0, 1'b0, 1'b0);
      queue_value(-1,      1'b0, 1'b0, 1'b0);
      queue_value(0,       1'b1, 1'b0, 1'b0);
      queue_value(-3,      1'b0, 1'b0, 1'b0);
      queue_value(-2,      1'b0, 1'b0, 1'b0);
      queue_value(5,       1'b0, 1'b0, 1'b0);
      queue_value(9,       1'b1, 1'b0, 1'b0);
      queue_value(100,     1'b0, 1'b0, 1'b0);
      queue_value(50,      1'b0, 1'b0, 1'b0);
      queue_value(-50,     1'b0, 1'b0, 1'b0);
      queue_value(-100,    1'b0, 1'b0, 1'b0);
      queue_value(VAL_MIN, 1'b1, 1'b0, 1'b0);
      queue_value(7,       1'b0, 1'b0, 1'b0);
      queue_value(7,       1'b0, 1'b0, 1'b0);
      queue_value(7,       1'b1, 1'b0, 1'b0);

      // Random sets: mostly small, one exactly full, two that overflow
      set_idx    = 0;
      rand_items = 0;
      while (rand_items < 330) begin
         case (set_idx)
            3:       n = CAPACITY;
            6:       n = CAPACITY + 1;
            9:       n = CAPACITY + 6;
            default: n = ($urandom_range(5) == 0) ? $urandom_range(20, 1)
                                                  : $urandom_range(8, 1);
         endcase
         burst = (rand_items >= 230 && rand_items < 290);
         queue_set(n, set_idx == 0 || set_idx == 3 || $urandom_range(9) == 0, burst);
         rand_items += n;
         set_idx++;
      end

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Drain: all transfers accepted, all results seen, then a quiet tail
      @(posedge clock);
      while (pending_q.size() != 0 || start) @(posedge clock);
      while (sorted_expect_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && sorted_expect_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/css_pkg.sv
hw/rtl/css_ram.sv
hw/rtl/css_dpath.sv
hw/rtl/css_ctrl.sv
hw/rtl/cocktail_shaker_sorter_core.sv
tb/testbench.sv
